FILE: design/assert_macros.svh
// Assertion macros for the bracket checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while out of reset.
`define BBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define BBC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/bbc_pkg.sv
// Types, codes and byte decoding for the bracket balance checker.
`timescale 1ns / 1ps
package bbc_pkg;

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_UNCLOSED = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  localparam logic [7:0] ChOpenRound   = 8'h28;
  localparam logic [7:0] ChOpenSquare  = 8'h5B;
  localparam logic [7:0] ChOpenCurly   = 8'h7B;
  localparam logic [7:0] ChCloseRound  = 8'h29;
  localparam logic [7:0] ChCloseSquare = 8'h5D;
  localparam logic [7:0] ChCloseCurly  = 8'h7D;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_e kind;
  } sym_t;

  // Shift command handed to every cell of the stack.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  function automatic sym_t decode_sym(logic [7:0] b);
    sym_t s;
    s = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    unique case (b)
      ChOpenRound:   s = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
      ChOpenSquare:  s = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      ChOpenCurly:   s = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
      ChCloseRound:  s = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
      ChCloseSquare: s = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      ChCloseCurly:  s = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
      default:       s = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    endcase
    return s;
  endfunction

endpackage

FILE: design/bbc_cell.sv
// One entry of the shifting bracket stack.
`timescale 1ns / 1ps
module bbc_cell
  import bbc_pkg::*;
(
  input  logic   clk_i,
  input  shift_t shift_i,
  input  kind_e  above_i,
  input  kind_e  below_i,
  output kind_e  kind_o
);

  kind_e kind_q, kind_d;

  always_comb begin
    priority if (shift_i.push) begin
      kind_d = above_i;
    end else if (shift_i.pop) begin
      kind_d = below_i;
    end else begin
      kind_d = kind_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign kind_o = kind_q;

endmodule

FILE: design/bbc_ctrl.sv
// Byte classification, depth and failure tracking, and the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bbc_ctrl
  import bbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] symbol_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       matched_o,
  output status_e    status_o,
  input  kind_e      top_kind_i,
  output kind_e      push_kind_o,
  output shift_t     shift_o
);

  localparam int unsigned DepthW = $clog2(STACK_DEPTH + 1);
  localparam logic [DepthW-1:0] Full = DepthW'(STACK_DEPTH);

  logic [DepthW-1:0] depth_q, depth_d;
  logic              failed_q, failed_d;
  status_e           reason_q, reason_d;
  logic              out_valid_q, out_valid_d;
  logic              matched_q, matched_d;
  status_e           status_q, status_d;

  logic              accept;
  sym_t              sym;
  logic              fail_now;
  status_e           fail_code;
  logic              push, pop;
  logic [DepthW-1:0] depth_after;
  status_e           report;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sym        = decode_sym(symbol_i);

  always_comb begin
    fail_now  = 1'b0;
    fail_code = ST_OK;
    push      = 1'b0;
    pop       = 1'b0;
    if (accept && !failed_q) begin
      if (sym.is_open) begin
        if (depth_q == Full) begin
          fail_now  = 1'b1;
          fail_code = ST_OVERFLOW;
        end else begin
          push = 1'b1;
        end
      end else if (sym.is_close) begin
        if (depth_q == '0 || top_kind_i != sym.kind) begin
          fail_now  = 1'b1;
          fail_code = ST_MISMATCH;
        end else begin
          pop = 1'b1;
        end
      end
    end
  end

  always_comb begin
    priority if (push) begin
      depth_after = depth_q + DepthW'(1);
    end else if (pop) begin
      depth_after = depth_q - DepthW'(1);
    end else begin
      depth_after = depth_q;
    end

    priority if (failed_q) begin
      report = reason_q;
    end else if (fail_now) begin
      report = fail_code;
    end else if (depth_after != '0) begin
      report = ST_UNCLOSED;
    end else begin
      report = ST_OK;
    end

    depth_d     = depth_after;
    failed_d    = failed_q || fail_now;
    reason_d    = fail_now ? fail_code : reason_q;
    out_valid_d = out_valid_q && !out_ready_i;
    matched_d   = matched_q;
    status_d    = status_q;

    if (accept && last_i) begin
      depth_d     = '0;
      failed_d    = 1'b0;
      reason_d    = ST_OK;
      out_valid_d = 1'b1;
      matched_d   = (report == ST_OK);
      status_d    = report;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      failed_q    <= 1'b0;
      reason_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      failed_q    <= failed_d;
      reason_q    <= reason_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    status_q  <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;
  assign status_o    = status_q;
  assign push_kind_o = sym.kind;
  assign shift_o     = '{push: push, pop: pop};

  `BBC_ASSERT(a_depth_bound, depth_q <= Full, "Stack depth beyond capacity.")
  `BBC_ASSERT(a_clear_after_last, accept && last_i |=> depth_q == '0 && !failed_q,
              "State not cleared after the last beat of a string.")
  `BBC_ASSERT(a_failed_freezes, failed_q && !(accept && last_i) |=> $stable(depth_q),
              "Stack moved after a failure.")
  `BBC_ASSERT_ALWAYS(a_one_shift, !(shift_o.push && shift_o.pop),
                     "Push and pop in the same cycle.")

endmodule

FILE: design/bracket_balance_checker.sv
// Top level of the bracket balance checker: controller and a shifting stack of cells.
//
//  Channel | Direction | tdata (low bit up)               | tlast
//  s_axis  | in        | symbol[7:0]                      | end_of_string
//  m_axis  | out       | matched, status[1:0], zero pad   | none
//
// One byte is accepted per cycle while no unread result blocks the input; the stack
// top sits in the first cell and a push or pop moves every cell by one place in that
// same cycle. A string's result appears in the cycle after its last beat and waits in
// an output register; input is taken whenever that register is empty or being read.
// Reset clears depth, failure state and the result valid flag at once.
`timescale 1ns / 1ps
module bracket_balance_checker
  import bbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] symbol
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [0] matched, [2:1] status, [7:3] zero
);

  kind_e   kinds [STACK_DEPTH];
  kind_e   push_kind;
  shift_t  shift;
  logic    matched;
  status_e status;

  bbc_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .symbol_i    (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .matched_o   (matched),
    .status_o    (status),
    .top_kind_i  (kinds[0]),
    .push_kind_o (push_kind),
    .shift_o     (shift)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_e above, below;
    if (i == 0) begin : g_top
      assign above = push_kind;
    end else begin : g_mid
      assign above = kinds[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = kinds[i];
    end else begin : g_up
      assign below = kinds[i+1];
    end
    bbc_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .above_i (above),
      .below_i (below),
      .kind_o  (kinds[i])
    );
  end

  assign m_axis_tdata_o = {5'b0, status, matched};

endmodule
